// ----- rtl/core/gia_pkg.sv -----
// Package for the group-indices-along-axis block: sizes, register codes,
// sequencer states and the row store record. Depends on nothing else.
package gia_pkg;

	// Store and field sizes.
	localparam int MAX_ROWS   = 256;
	localparam int MAX_RANK   = 4;
	localparam int NUM_COORDS = 4;
	localparam int COORD_BITS = 32;
	localparam int ADDR_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W      = $clog2(MAX_ROWS + 1);
	localparam int SLOT_W     = 8;
	localparam int EXTENT_W   = 9;
	localparam int VALUE_W    = 33;
	localparam int SLOT_MAX   = 255;
	localparam int EXTENT_MAX = 511;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int RANK_W     = 3;
	localparam int AXIS_W     = 2;

	// Configuration register select (byte address bit 2).
	localparam logic REG_RANK = 1'b0;
	localparam logic REG_AXIS = 1'b1;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] key_t;

	// One stored row: group key, slot inside the group, original axis value.
	typedef struct packed {
		key_t                  key;
		logic [SLOT_W-1:0]     slot;
		logic [COORD_BITS-1:0] axis;
	} row_t;

	// Address and enable of one port of the row store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ----- rtl/core/group_indices_along_axis_top.sv -----
// Top level of the group-indices-along-axis block: configuration registers,
// scan sequencer and result register. Depends on gia_pkg and gia_row_store.
//
//   channel   direction  handshake                      payload
//   item      in         item_valid / item_stall        kind, coord_0 .. coord_3
//   result    out        result_valid / result_stall    value, slot, extent, dropped
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each item is captured, then every stored row is read through the single read
// port of the row store and compared against the item's key (no compare with an
// empty store), then the scan is left and the item commits; a load into a full
// store skips the scan and is dropped. Reset clears the row count, the largest
// group size, the sequencer and result_valid, and sets rank to MAX_RANK, axis to 0.
// item_stall is high while an item is in work; a stalled result stays in its
// register and a finished item waits until that register is free.
module group_indices_along_axis_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item channel.
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                kind,
	input  logic [gia_pkg::COORD_BITS-1:0]      coord_0,
	input  logic [gia_pkg::COORD_BITS-1:0]      coord_1,
	input  logic [gia_pkg::COORD_BITS-1:0]      coord_2,
	input  logic [gia_pkg::COORD_BITS-1:0]      coord_3,
	// Result channel.
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [gia_pkg::VALUE_W-1:0]  value,
	output logic [gia_pkg::SLOT_W-1:0]          slot,
	output logic [gia_pkg::EXTENT_W-1:0]        extent,
	output logic                                dropped,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gia_pkg::PADDR_W-1:0]         paddr,
	input  logic [gia_pkg::PDATA_W-1:0]         pwdata,
	output logic [gia_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int CW = gia_pkg::COORD_BITS;

	gia_pkg::state_t state_q, state_d;

	logic [gia_pkg::RANK_W-1:0]   rank_q;
	logic [gia_pkg::AXIS_W-1:0]   axis_sel_q;
	logic [gia_pkg::CNT_W-1:0]    rows_held_q;
	logic [gia_pkg::EXTENT_W-1:0] largest_q;
	logic [gia_pkg::CNT_W-1:0]    issue_cnt_q;
	logic                         rd_vld_q;
	logic                         result_valid_q;

	logic                         kind_q;
	logic                         drop_q;
	gia_pkg::key_t                key_q;
	logic [CW-1:0]                axis_q;
	logic [gia_pkg::CNT_W-1:0]    count_q;
	logic                         found_q;
	logic [CW-1:0]                found_val_q;

	logic signed [gia_pkg::VALUE_W-1:0] value_q;
	logic [gia_pkg::SLOT_W-1:0]         slot_q;
	logic [gia_pkg::EXTENT_W-1:0]       extent_q;
	logic                               dropped_q;

	logic                         cfg_write;
	logic                         accept;
	logic                         full;
	logic                         issue;
	logic                         commit;
	logic                         stored;
	logic                         row_match;
	logic                         slot_match;
	logic [gia_pkg::RANK_W-1:0]   eff_rank;
	logic [CW-1:0]                coord_in [gia_pkg::NUM_COORDS];
	gia_pkg::key_t                key_in;
	logic [CW-1:0]                axis_in;
	logic [31:0]                  count_w;
	logic [31:0]                  size_w;
	logic [gia_pkg::SLOT_W-1:0]   slot_sat;
	logic [gia_pkg::EXTENT_W-1:0] size_sat;
	logic [gia_pkg::EXTENT_W-1:0] largest_d;

	gia_pkg::ram_req_t wr_req;
	gia_pkg::ram_req_t rd_req;
	gia_pkg::row_t     wr_data;
	gia_pkg::row_t     rd_data;

	// Configuration registers; each write transfer updates one of them.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q     <= gia_pkg::RANK_W'(gia_pkg::MAX_RANK);
			axis_sel_q <= '0;
		end else if (cfg_write) begin
			case (paddr[2])
				gia_pkg::REG_RANK: rank_q     <= pwdata[gia_pkg::RANK_W-1:0];
				gia_pkg::REG_AXIS: axis_sel_q <= pwdata[gia_pkg::AXIS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			gia_pkg::REG_RANK: prdata = gia_pkg::PDATA_W'(rank_q);
			gia_pkg::REG_AXIS: prdata = gia_pkg::PDATA_W'(axis_sel_q);
			default:           prdata = '0;
		endcase
	end

	// Group key of the incoming item: unused coordinates read as zero and the
	// axis coordinate is pulled out and zeroed.
	assign coord_in[0] = coord_0;
	assign coord_in[1] = coord_1;
	assign coord_in[2] = coord_2;
	assign coord_in[3] = coord_3;

	always_comb begin
		if (rank_q == '0) begin
			eff_rank = gia_pkg::RANK_W'(1);
		end else if (rank_q > gia_pkg::RANK_W'(gia_pkg::MAX_RANK)) begin
			eff_rank = gia_pkg::RANK_W'(gia_pkg::MAX_RANK);
		end else begin
			eff_rank = rank_q;
		end
		for (int i = 0; i < gia_pkg::NUM_COORDS; i++) begin
			key_in[i] = (gia_pkg::RANK_W'(i) < eff_rank) ? coord_in[i] : '0;
		end
		axis_in             = key_in[axis_sel_q];
		key_in[axis_sel_q]  = '0;
	end

	// Handshake and scan control.
	assign item_stall = (state_q != gia_pkg::ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign full       = (rows_held_q == gia_pkg::CNT_W'(gia_pkg::MAX_ROWS));
	assign issue      = (state_q == gia_pkg::ST_SCAN) && (issue_cnt_q < rows_held_q);
	assign commit     = (state_q == gia_pkg::ST_FINISH) && (!result_valid_q || !result_stall);
	assign stored     = commit && (kind_q == gia_pkg::KIND_LOAD) && !drop_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			gia_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (kind == gia_pkg::KIND_LOAD && full) ?
						gia_pkg::ST_FINISH : gia_pkg::ST_SCAN;
				end
			end
			gia_pkg::ST_SCAN: begin
				if (!issue && !rd_vld_q) begin
					state_d = gia_pkg::ST_FINISH;
				end
			end
			gia_pkg::ST_FINISH: begin
				if (commit) begin
					state_d = gia_pkg::ST_IDLE;
				end
			end
			default: state_d = gia_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gia_pkg::ST_IDLE;
			issue_cnt_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issue;
			if (accept) begin
				issue_cnt_q <= '0;
			end else if (issue) begin
				issue_cnt_q <= issue_cnt_q + gia_pkg::CNT_W'(1);
			end
		end
	end

	// Row store: one row read per scan cycle, one row written at commit.
	assign rd_req.en   = issue;
	assign rd_req.addr = issue_cnt_q[gia_pkg::ADDR_W-1:0];
	assign wr_req.en   = stored;
	assign wr_req.addr = rows_held_q[gia_pkg::ADDR_W-1:0];
	assign wr_data.key  = key_q;
	assign wr_data.slot = slot_sat;
	assign wr_data.axis = axis_q;

	gia_row_store u_row_store (
		.clk     (clk),
		.wr_req  (wr_req),
		.wr_data (wr_data),
		.rd_req  (rd_req),
		.rd_data (rd_data)
	);

	// Compare of the row read in the previous cycle against the item's key.
	assign row_match  = (rd_data.key == key_q);
	assign slot_match = (CW'(rd_data.slot) == axis_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			key_q   <= key_in;
			axis_q  <= axis_in;
			drop_q  <= (kind == gia_pkg::KIND_LOAD) && full;
			count_q <= '0;
			found_q <= 1'b0;
		end else if (rd_vld_q && row_match) begin
			if (kind_q == gia_pkg::KIND_LOAD) begin
				count_q <= count_q + gia_pkg::CNT_W'(1);
			end else if (slot_match && !found_q) begin
				found_q     <= 1'b1;
				found_val_q <= rd_data.axis;
			end
		end
	end

	// Saturated slot and group size of a stored row.
	assign count_w  = 32'(count_q);
	assign size_w   = count_w + 32'd1;
	assign slot_sat = (count_w > 32'(gia_pkg::SLOT_MAX)) ?
		gia_pkg::SLOT_W'(gia_pkg::SLOT_MAX) : gia_pkg::SLOT_W'(count_w);
	assign size_sat = (size_w > 32'(gia_pkg::EXTENT_MAX)) ?
		gia_pkg::EXTENT_W'(gia_pkg::EXTENT_MAX) : gia_pkg::EXTENT_W'(size_w);
	assign largest_d = (stored && size_sat > largest_q) ? size_sat : largest_q;

	// Row count and largest group size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_held_q <= '0;
			largest_q   <= '0;
		end else if (stored) begin
			rows_held_q <= rows_held_q + gia_pkg::CNT_W'(1);
			largest_q   <= largest_d;
		end
	end

	// Result register; a stalled result holds until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (kind_q == gia_pkg::KIND_QUERY) begin
				value_q <= found_q ? $signed({1'b0, found_val_q}) : '1;
			end else begin
				value_q <= '0;
			end
			slot_q    <= stored ? slot_sat : '0;
			extent_q  <= largest_d;
			dropped_q <= drop_q;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign slot         = slot_q;
	assign extent       = extent_q;
	assign dropped      = dropped_q;

endmodule

// ----- rtl/core/gia_row_store.sv -----
// Row store of the group-indices-along-axis block: one write port and one
// read port with registered read data. Depends on gia_pkg.
module gia_row_store (
	input  logic             clk,
	input  gia_pkg::ram_req_t wr_req,
	input  gia_pkg::row_t    wr_data,
	input  gia_pkg::ram_req_t rd_req,
	output gia_pkg::row_t    rd_data
);

	gia_pkg::row_t mem_q [gia_pkg::MAX_ROWS];
	gia_pkg::row_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem_q[wr_req.addr] <= wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data_q <= mem_q[rd_req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- verif/group_indices_along_axis_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for group_indices_along_axis_top: loads index rows and
// dense queries under several rank and axis settings and checks every result
// against a built-in grouping predictor. Depends on gia_pkg and the RTL top level.
module group_indices_along_axis_top_tb;

	localparam int RANDOM_PER_PHASE = 200;
	localparam int NUM_PHASES       = 8;
	localparam int IDLE_PCT         = 8;
	localparam int LOAD_PCT         = 30;
	localparam int HOLD_CYCLES      = 700;
	localparam int SETTLE_CYCLES    = 300;
	localparam int STALL_LIMIT      = 5000;
	localparam int RECENT_DEPTH     = 32;

	// One input item and one result, laid out as on the ports.
	typedef struct packed {
		logic          kind;
		gia_pkg::key_t coord;
	} row_item_t;

	typedef struct packed {
		logic [gia_pkg::VALUE_W-1:0]  value;
		logic [gia_pkg::SLOT_W-1:0]   slot;
		logic [gia_pkg::EXTENT_W-1:0] extent;
		logic                         dropped;
	} answer_t;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           item_valid   = 1'b0;
	logic                           item_stall;
	logic                           kind         = gia_pkg::KIND_LOAD;
	logic [gia_pkg::COORD_BITS-1:0] coord_0      = '0;
	logic [gia_pkg::COORD_BITS-1:0] coord_1      = '0;
	logic [gia_pkg::COORD_BITS-1:0] coord_2      = '0;
	logic [gia_pkg::COORD_BITS-1:0] coord_3      = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	logic [gia_pkg::VALUE_W-1:0]    value;
	logic [gia_pkg::SLOT_W-1:0]     slot;
	logic [gia_pkg::EXTENT_W-1:0]   extent;
	logic                           dropped;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [gia_pkg::PADDR_W-1:0]    paddr        = '0;
	logic [gia_pkg::PDATA_W-1:0]    pwdata       = '0;
	logic [gia_pkg::PDATA_W-1:0]    prdata;
	logic                           pready;

	// Items waiting to be driven and results waiting to be seen.
	row_item_t item_backlog [$];
	answer_t   pending_answers [$];

	// Predictor copy of the row store and the registers.
	gia_pkg::key_t                  grp_key [gia_pkg::MAX_ROWS];
	logic [gia_pkg::SLOT_W-1:0]     grp_slot [gia_pkg::MAX_ROWS];
	logic [gia_pkg::COORD_BITS-1:0] grp_axis_val [gia_pkg::MAX_ROWS];
	int                             rows_kept    = 0;
	int                             widest_group = 0;
	logic [gia_pkg::RANK_W-1:0]     cfg_rank     = 3'd4;
	logic [gia_pkg::AXIS_W-1:0]     cfg_axis     = 2'd0;

	int failures     = 0;
	int answers_seen = 0;
	int idle_cycles  = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	bit calm         = 1'b0;

	int phase_rank [NUM_PHASES] = '{3, 4, 1, 2, 7, 5, 0, 4};
	int phase_axis [NUM_PHASES] = '{1, 2, 0, 1, 3, 0, 2, 3};

	group_indices_along_axis_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.coord_0      (coord_0),
		.coord_1      (coord_1),
		.coord_2      (coord_2),
		.coord_3      (coord_3),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.slot         (slot),
		.extent       (extent),
		.dropped      (dropped),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	// Forms the group key, then either stores the row with its next slot in the
	// group or looks up the stored axis value for the queried slot.
	function automatic answer_t group_and_lookup(row_item_t it);
		gia_pkg::key_t                  k;
		logic [gia_pkg::COORD_BITS-1:0] axis_coord;
		int                             used;
		int                             count;
		int                             i;
		answer_t                        ans;
		if (cfg_rank == 0)
			used = 1;
		else if (cfg_rank > gia_pkg::MAX_RANK)
			used = gia_pkg::MAX_RANK;
		else
			used = int'(cfg_rank);
		for (i = 0; i < gia_pkg::NUM_COORDS; i++)
			k[i] = (i < used) ? it.coord[i] : '0;
		axis_coord = k[cfg_axis];
		k[cfg_axis] = '0;
		ans = '0;
		if (it.kind == gia_pkg::KIND_LOAD) begin
			if (rows_kept >= gia_pkg::MAX_ROWS) begin
				ans.dropped = 1'b1;
			end else begin
				count = 0;
				for (i = 0; i < rows_kept; i++)
					if (grp_key[i] == k)
						count++;
				ans.slot = gia_pkg::SLOT_W'((count > gia_pkg::SLOT_MAX) ?
					gia_pkg::SLOT_MAX : count);
				grp_key[rows_kept] = k;
				grp_slot[rows_kept] = ans.slot;
				grp_axis_val[rows_kept] = axis_coord;
				rows_kept++;
				if (count + 1 > widest_group)
					widest_group = (count + 1 > gia_pkg::EXTENT_MAX) ?
						gia_pkg::EXTENT_MAX : count + 1;
			end
		end else begin
			// A miss, or an axis coordinate beyond any slot, answers -1.
			ans.value = '1;
			if (axis_coord <= gia_pkg::SLOT_MAX) begin
				for (i = 0; i < rows_kept; i++) begin
					if (grp_key[i] == k &&
							grp_slot[i] == axis_coord[gia_pkg::SLOT_W-1:0]) begin
						ans.value = {1'b0, grp_axis_val[i]};
						break;
					end
				end
			end
		end
		ans.extent = gia_pkg::EXTENT_W'(widest_group);
		return ans;
	endfunction

	function automatic row_item_t make_item(logic k, logic [gia_pkg::COORD_BITS-1:0] c0,
			logic [gia_pkg::COORD_BITS-1:0] c1, logic [gia_pkg::COORD_BITS-1:0] c2,
			logic [gia_pkg::COORD_BITS-1:0] c3);
		row_item_t it;
		it.kind = k;
		it.coord = {c3, c2, c1, c0};
		return it;
	endfunction

	// Appends one item to the end of the backlog.
	task automatic queue_item(input row_item_t it);
		item_backlog.insert(item_backlog.size(), it);
	endtask

	// Mostly small coordinates so that keys collide, sometimes any 32-bit value.
	function automatic logic [gia_pkg::COORD_BITS-1:0] any_coord();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return gia_pkg::COORD_BITS'($urandom_range(0, 3));
		else if (pick < 95)
			return gia_pkg::COORD_BITS'($urandom);
		else
			return '1;
	endfunction

	// Register write: setup cycle, then access cycle; the write lands at the
	// edge that ends the access cycle.
	task automatic write_reg(input logic sel, input logic [gia_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == gia_pkg::REG_RANK)
			cfg_rank = data[gia_pkg::RANK_W-1:0];
		else
			cfg_axis = data[gia_pkg::AXIS_W-1:0];
	endtask

	// Waits until every item has been taken and every result has come back.
	task automatic wait_until_quiet();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || item_valid || pending_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Item driver: offers the next pending item, with random gaps.
	always @(posedge clk) begin
		row_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (item_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = item_backlog.pop_front();
				item_valid <= 1'b1;
				kind <= nxt.kind;
				coord_0 <= nxt.coord[0];
				coord_1 <= nxt.coord[1];
				coord_2 <= nxt.coord[2];
				coord_3 <= nxt.coord[3];
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, and one long hold-off while items keep coming.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (!hold_done && answers_seen >= 200 && item_backlog.size() > 20) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Monitor: checks each result transfer, then predicts each accepted item.
	always @(posedge clk) begin
		answer_t got;
		answer_t exp;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got = {value, slot, extent, dropped};
				answers_seen++;
				if (pending_answers.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: value=%h slot=%0d extent=%0d dropped=%0b",
							got.value, got.slot, got.extent, got.dropped);
				end else begin
					exp = pending_answers.pop_front();
					if (got !== exp) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: expected value=%h slot=%0d extent=%0d dropped=%0b, %s",
								exp.value, exp.slot, exp.extent, exp.dropped,
								$sformatf("got value=%h slot=%0d extent=%0d dropped=%0b",
									got.value, got.slot, got.extent, got.dropped));
					end
				end
			end
			if (item_valid && !item_stall)
				pending_answers.insert(pending_answers.size(),
					group_and_lookup({kind, coord_3, coord_2, coord_1, coord_0}));
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed cases under a few settings, then random phases.
	initial begin
		row_item_t     it;
		gia_pkg::key_t recent [$];
		int            ph;
		int            n;
		int            i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Full rank, axis 0: duplicates, extremes, hits and misses.
		write_reg(gia_pkg::REG_RANK, 4);
		write_reg(gia_pkg::REG_AXIS, 0);
		queue_item(make_item(gia_pkg::KIND_LOAD, 1, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_LOAD, 5, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_LOAD, 5, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_LOAD, '1, '1, '1, '1));
		queue_item(make_item(gia_pkg::KIND_LOAD, 0, 0, 0, 0));
		queue_item(make_item(gia_pkg::KIND_QUERY, 0, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_QUERY, 2, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_QUERY, 3, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_QUERY, 0, '1, '1, '1));
		queue_item(make_item(gia_pkg::KIND_QUERY, 256, 2, 3, 4));
		queue_item(make_item(gia_pkg::KIND_QUERY, '1, 2, 3, 4));
		wait_until_quiet();

		// Rank zero acts as one: every key collapses to zero.
		write_reg(gia_pkg::REG_RANK, 0);
		queue_item(make_item(gia_pkg::KIND_LOAD, 7, 9, 9, 9));
		queue_item(make_item(gia_pkg::KIND_QUERY, 1, 1, 1, 1));
		queue_item(make_item(gia_pkg::KIND_QUERY, 7, 5, 5, 5));
		wait_until_quiet();

		// Rank above the maximum acts as full rank, last coordinate as axis.
		write_reg(gia_pkg::REG_RANK, 7);
		write_reg(gia_pkg::REG_AXIS, 3);
		queue_item(make_item(gia_pkg::KIND_LOAD, 1, 2, 3, 9));
		queue_item(make_item(gia_pkg::KIND_QUERY, 1, 2, 3, 0));
		wait_until_quiet();

		// Axis at or above rank: the axis coordinate reads as zero.
		write_reg(gia_pkg::REG_RANK, 2);
		queue_item(make_item(gia_pkg::KIND_LOAD, 4, 5, 6, 7));
		queue_item(make_item(gia_pkg::KIND_LOAD, 4, 5, 8, 8));
		queue_item(make_item(gia_pkg::KIND_QUERY, 4, 5, 1, 1));
		wait_until_quiet();

		// Random phases; queries mostly reuse a recent row so that they can hit.
		// The store fills partway through, after which loads are dropped.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_reg(gia_pkg::REG_RANK, phase_rank[ph]);
			write_reg(gia_pkg::REG_AXIS, phase_axis[ph]);
			calm = (ph == 1);
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				it.kind = ($urandom_range(0, 99) < LOAD_PCT) ?
					gia_pkg::KIND_LOAD : gia_pkg::KIND_QUERY;
				for (i = 0; i < gia_pkg::NUM_COORDS; i++)
					it.coord[i] = any_coord();
				if (it.kind == gia_pkg::KIND_LOAD) begin
					recent.insert(recent.size(), it.coord);
					if (recent.size() > RECENT_DEPTH)
						void'(recent.pop_front());
				end else if (recent.size() > 0 && $urandom_range(0, 99) < 65) begin
					it.coord = recent[$urandom_range(0, recent.size() - 1)];
					it.coord[cfg_axis] = gia_pkg::COORD_BITS'($urandom_range(0, 5));
				end
				queue_item(it);
			end
			wait_until_quiet();
		end
		calm = 1'b0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending_answers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
